/* rtl/ksss_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the k-sorted stream sorter.
// Used by ksss_cell and k_sorted_stream_sorter; depends on nothing.
package ksss_pkg;

  localparam int KEY_W = 32;
  localparam int WIN_W = 5;
  localparam int MAX_WINDOW_DEF = 16;
  localparam logic [WIN_W-1:0] WIN_RESET = 5'd16;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } ksss_state_t;

  typedef struct packed {
    logic ins;
    logic rep;
    logic shf;
  } ksss_op_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    valid;
    logic                    gt;
  } ksss_link_t;

endpackage

/* rtl/k_sorted_stream_sorter.sv */
`timescale 1ns / 1ps
// Top level of the k-sorted stream sorter: sequencer, output register and cell chain.
// Depends on ksss_pkg and ksss_cell.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       tdata key_in, tlast end_of_stream
//   m_axis    out        m_axis_tvalid/tready       tdata key_out, tlast last_out
//   cfg       in         cfg_we                     cfg_wdata window_k
//
// An accepted request updates every cell of the chain together, so keys enter at one per
// cycle while the output register is free or being emptied.
// After a request with tlast, the chain drains one held key per cycle toward the head while the output
// register is free, and no request is taken until the last key has been loaded into the output register.
// A stall on m_axis holds the output register and closes s_axis_tready.
// Reset empties the chain at once and sets window_k to 16.
module k_sorted_stream_sorter #(
  parameter int MAX_WINDOW = ksss_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ksss_pkg::KEY_W-1:0]       s_axis_tdata,   // [31:0] key_in
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ksss_pkg::KEY_W-1:0]       m_axis_tdata,   // [31:0] key_out
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [ksss_pkg::WIN_W-1:0]       cfg_wdata
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int EW = (CW > ksss_pkg::WIN_W) ? CW : ksss_pkg::WIN_W;

  ksss_pkg::ksss_state_t state;
  ksss_pkg::ksss_state_t state_next;
  logic [CW-1:0]                window_cnt;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                cnt_next;
  logic [ksss_pkg::WIN_W-1:0]   window_k;
  logic [EW-1:0]                win_ext;
  logic [EW-1:0]                keff;
  logic                         fill;
  logic                         acc;
  logic                         out_free;
  logic                         load;
  logic                         load_last;
  ksss_pkg::ksss_op_t           op;
  logic signed [ksss_pkg::KEY_W-1:0] x;
  ksss_pkg::ksss_link_t         links [0:MAX_WINDOW+1];
  logic [MAX_WINDOW-1:0]        vbits;
  logic                         out_valid;
  logic [ksss_pkg::KEY_W-1:0]   out_key;
  logic                         out_last;

  assign win_ext = EW'(window_k);

  always_comb begin
    if (win_ext == '0) begin
      keff = EW'(1);
    end else if (win_ext > EW'(MAX_WINDOW)) begin
      keff = EW'(MAX_WINDOW);
    end else begin
      keff = win_ext;
    end
  end

  assign window_cnt    = cnt;
  assign fill          = EW'(window_cnt) < keff;
  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ksss_pkg::ST_RUN) && out_free;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign x             = $signed(s_axis_tdata);

  always_comb begin
    state_next = state;
    unique case (state)
      ksss_pkg::ST_RUN: begin
        if (acc && s_axis_tlast) begin
          state_next = ksss_pkg::ST_DRAIN;
        end
      end
      ksss_pkg::ST_DRAIN: begin
        if (out_free && cnt == CW'(1)) begin
          state_next = ksss_pkg::ST_RUN;
        end
      end
      default: state_next = ksss_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    op        = '0;
    load      = 1'b0;
    load_last = 1'b0;
    cnt_next  = cnt;
    unique case (state)
      ksss_pkg::ST_RUN: begin
        if (acc) begin
          if (fill) begin
            op.ins   = 1'b1;
            cnt_next = cnt + CW'(1);
          end else begin
            op.rep = 1'b1;
            load   = 1'b1;
          end
        end
      end
      ksss_pkg::ST_DRAIN: begin
        if (out_free) begin
          op.shf    = 1'b1;
          load      = 1'b1;
          load_last = (cnt == CW'(1));
          cnt_next  = cnt - CW'(1);
        end
      end
      default: begin
        op = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ksss_pkg::ST_RUN;
      cnt       <= '0;
      window_k  <= ksss_pkg::WIN_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_we) begin
        window_k <= cfg_wdata;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_key  <= links[1].key;
      out_last <= load_last;
    end
  end

  assign links[0].key             = '0;
  assign links[0].valid           = 1'b1;
  assign links[0].gt              = 1'b0;
  assign links[MAX_WINDOW+1].key   = '0;
  assign links[MAX_WINDOW+1].valid = 1'b0;
  assign links[MAX_WINDOW+1].gt    = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    ksss_cell #(
      .HEAD(i == 0)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .op  (op),
      .x   (x),
      .prev(links[i]),
      .nxt (links[i+2]),
      .own (links[i+1])
    );
    assign vbits[i] = links[i+1].valid;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_key;
  assign m_axis_tlast  = out_last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_WINDOW))
    else $error("held count exceeds the chain length");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    $countones(vbits) == int'(cnt))
    else $error("cell valid bits disagree with the held count");

  a_drain_closed: assert property (@(posedge clk) disable iff (rst)
    state == ksss_pkg::ST_DRAIN |-> !s_axis_tready)
    else $error("request taken while draining");

  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> cnt == '0)
    else $error("final key shown while keys are still held");

endmodule

/* rtl/ksss_cell.sv */
`timescale 1ns / 1ps
// One cell of the sorted key chain: holds one key and its valid bit.
// Depends on ksss_pkg for the operation and link types.
module ksss_cell #(
  parameter bit HEAD = 1'b0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ksss_pkg::ksss_op_t                op,
  input  logic signed [ksss_pkg::KEY_W-1:0] x,
  input  ksss_pkg::ksss_link_t              prev,
  input  ksss_pkg::ksss_link_t              nxt,
  output ksss_pkg::ksss_link_t              own
);

  logic signed [ksss_pkg::KEY_W-1:0] key;
  logic signed [ksss_pkg::KEY_W-1:0] key_next;
  logic                              valid;
  logic                              valid_next;
  logic                              gt;

  assign gt = valid && (key > x);

  always_comb begin
    key_next   = key;
    valid_next = valid;
    if (op.ins) begin
      valid_next = valid | prev.valid;
      if (prev.gt) begin
        key_next = prev.key;
      end else if (gt || (!valid && prev.valid)) begin
        key_next = x;
      end
    end else if (op.rep) begin
      if (!HEAD && gt) begin
        key_next = key;
      end else if (nxt.gt || (!nxt.valid && valid)) begin
        key_next = x;
      end else begin
        key_next = nxt.key;
      end
    end else if (op.shf) begin
      key_next   = nxt.key;
      valid_next = nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  assign own.key   = key;
  assign own.valid = valid;
  assign own.gt    = gt;

endmodule
